FILE: src/glu_pkg.sv
// Shared widths and divider handshake types for the GCD/LCM unit.
package glu_pkg;

    localparam int GLU_W   = 32;
    localparam int GLU_CW  = $clog2(GLU_W);
    localparam int GLU_PW  = 2 * GLU_W;

    typedef logic [GLU_W-1:0]  t_word;
    typedef logic [GLU_PW-1:0] t_prod;

    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quotient;
    } t_div_rsp;

endpackage

FILE: src/glu_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module glu_divider import glu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [GLU_CW-1:0] r_cnt, n_cnt;
    t_word             r_rem, n_rem;
    t_word             r_quo, n_quo;
    t_word             r_den, n_den;
    logic [GLU_W:0]    shifted;
    logic [GLU_W:0]    trial;

    // Shift in the next dividend bit and try the subtraction.
    assign shifted = {r_rem, r_quo[GLU_W-1]};
    assign trial   = shifted - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            if (!trial[GLU_W]) begin
                n_rem = trial[GLU_W-1:0];
                n_quo = {r_quo[GLU_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[GLU_W-1:0];
                n_quo = {r_quo[GLU_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == GLU_CW'(GLU_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: src/gcd_lcm_unit_top.sv
// GCD/LCM unit top: request sequencer, binary GCD loop, divider, product, result register.
//
// Usage:
//   Input channel: a request carries i_first_value and i_second_value. It is
//   accepted at a rising edge with i_in_valid high and o_in_stall low.
//   Output channel: o_divisor_result, o_multiple_result and o_undefined_flag
//   are taken at a rising edge with o_out_valid high and i_out_stall low.
//   One request is worked on at a time; o_in_stall is high from acceptance
//   until its result has been moved into the output register.
// Sequence:
//   A zero operand: from acceptance the sequencer goes straight to its final
//   state, which loads the output register once it is free.
//   Otherwise: the binary GCD loop (one subtract or shift per cycle, its length
//   set by operand bit lengths and common factors of two), then the one-bit-per-cycle
//   divider for first/gcd, then the 32x32 product and the load of the result.
// Stall: the output register holds its result while i_out_stall is high; the
//   next request may be accepted and worked on meanwhile, and it waits in its
//   final state until the output register is free.
// Reset: synchronous, active low; clears the sequencer and o_out_valid.
module gcd_lcm_unit_top import glu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_first_value,
    input  logic [31:0] i_second_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_divisor_result,
    output logic [63:0] o_multiple_result,
    output logic        o_undefined_flag
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        r_state, n_state;
    t_word             r_a, n_a;
    t_word             r_b, n_b;
    logic [GLU_CW-1:0] r_k, n_k;
    t_word             r_first, n_first;
    t_word             r_second, n_second;
    t_word             r_g, n_g;
    t_word             r_q, n_q;
    t_prod             r_prod, n_prod;
    logic              r_flag, n_flag;

    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_out_div;
    logic [63:0]       r_out_mul;
    logic              r_out_flag;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic              accept;
    logic              out_free;
    logic              a_gt_b;
    t_word             big;
    t_word             little;
    t_word             diff;
    t_word             in_a;
    t_word             in_b;

    // Mask operands to the working width.
    assign in_a = i_first_value[GLU_W-1:0];
    assign in_b = i_second_value[GLU_W-1:0];

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // One shared compare and subtract for the GCD loop.
    assign a_gt_b = (r_a > r_b);
    assign big    = a_gt_b ? r_a : r_b;
    assign little = a_gt_b ? r_b : r_a;
    assign diff   = big - little;

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        n_first  = r_first;
        n_second = r_second;
        n_g      = r_g;
        n_q      = r_q;
        n_prod   = r_prod;
        n_flag   = r_flag;
        div_req.start    = 1'b0;
        div_req.dividend = r_first;
        div_req.divisor  = r_a << r_k;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_first  = in_a;
                    n_second = in_b;
                    n_a      = in_a;
                    n_b      = in_b;
                    n_k      = '0;
                    n_prod   = '0;
                    n_flag   = (in_a == '0) && (in_b == '0);
                    if ((in_a == '0) || (in_b == '0)) begin
                        // A zero operand yields the other one.
                        n_g     = in_a | in_b;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                priority if (r_a == r_b) begin
                    // Restore the common powers of two and start first/gcd.
                    n_g           = r_a << r_k;
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (a_gt_b) begin
                    n_a = diff >> 1;
                end else begin
                    n_b = diff >> 1;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_q     = div_rsp.quotient;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = GLU_PW'(r_q) * GLU_PW'(r_second);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load when the sequencer finishes, drop when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_DONE && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_k      <= n_k;
        r_first  <= n_first;
        r_second <= n_second;
        r_g      <= n_g;
        r_q      <= n_q;
        r_prod   <= n_prod;
        r_flag   <= n_flag;
        if (r_state == S_DONE && out_free) begin
            r_out_div  <= 32'(r_g);
            r_out_mul  <= 64'(r_prod);
            r_out_flag <= r_flag;
        end
    end

    glu_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out_valid       = r_out_valid;
    assign o_divisor_result  = r_out_div;
    assign o_multiple_result = r_out_mul;
    assign o_undefined_flag  = r_out_flag;

endmodule

FILE: tb/tb_gcd_lcm_unit_top.sv
// Self-checking testbench for gcd_lcm_unit_top: directed and random operand pairs.
module tb_gcd_lcm_unit_top;
    import glu_pkg::*;

    localparam int N_DIRECTED  = 20;
    localparam int N_RANDOM    = 1600;
    localparam int HOLD_CYCLES = 400;     // long output hold-off, well past two requests
    localparam int TAIL_CYCLES = 200;     // quiet time after the last result
    localparam int CYCLE_LIMIT = 1500000; // bound for the watchdog below

    // One outstanding request together with the result it must produce.
    typedef struct packed {
        t_word a;
        t_word b;
        t_word divisor;
        t_prod multiple;
        logic  undef;
    } t_gcd_lcm_req;

    // Directed row: operands, and a typed-in answer where it is obvious.
    typedef struct packed {
        t_word a;
        t_word b;
        logic  typed;
        t_word divisor;
        t_prod multiple;
        logic  undef;
    } t_dir_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_first_value  = '0;
    logic [31:0] i_second_value = '0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [31:0] o_divisor_result;
    logic [63:0] o_multiple_result;
    logic        o_undefined_flag;

    t_gcd_lcm_req pending_res [$];   // results still owed by the block, oldest first

    int   errors      = 0;
    int   n_checked   = 0;
    int   n_sent      = 0;
    int   n_zero_ops  = 0;
    int   n_holds     = 0;
    int   cycle_count = 0;
    logic in_idle_on  = 1'b1;
    logic out_idle_on = 1'b1;
    logic hold_off_req = 1'b0;

    // Typed rows: both zero, one zero, ones, all-ones and the top bit alone.
    // Untyped rows go through the predictor: coprime, shared factors, powers
    // of two and the consecutive Fibonacci pair that runs Euclid longest.
    t_dir_row dir_rows [0:N_DIRECTED-1] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 64'h0, 1'b1},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 64'h0, 1'b0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 64'h0, 1'b0},
        '{32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0001, 64'h0, 1'b0},
        '{32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0001, 64'h0, 1'b0},
        '{32'h0000_0003, 32'h0000_0000, 1'b1, 32'h0000_0003, 64'h0, 1'b0},
        '{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0001, 64'h1, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF, 1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'h0000_0001, 64'hFFFF_FFFD_0000_0002, 1'b0},
        '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 64'h8000_0000, 1'b0},
        '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001, 64'hFFFF_FFFF, 1'b0},
        '{32'h8000_0000, 32'h0000_0001, 1'b0, 32'h0, 64'h0, 1'b0},
        '{32'h8000_0000, 32'h4000_0000, 1'b0, 32'h0, 64'h0, 1'b0},
        '{32'd12,        32'd18,        1'b0, 32'h0, 64'h0, 1'b0},
        '{32'd7,         32'd13,        1'b0, 32'h0, 64'h0, 1'b0},
        '{32'd1071,      32'd462,       1'b0, 32'h0, 64'h0, 1'b0},
        '{32'd1836311903, 32'd2971215073, 1'b0, 32'h0, 64'h0, 1'b0},
        '{32'hFFFF_FFFE, 32'h0000_0002, 1'b0, 32'h0, 64'h0, 1'b0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0, 64'h0, 1'b0},
        '{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, 32'h0, 64'h0, 1'b0}
    };

    gcd_lcm_unit_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_first_value     (i_first_value),
        .i_second_value    (i_second_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_divisor_result  (o_divisor_result),
        .o_multiple_result (o_multiple_result),
        .o_undefined_flag  (o_undefined_flag)
    );

    always #2 i_clk = ~i_clk;

    // Euclid by repeated remainder; a zero operand leaves the other as divisor.
    // The multiple is (a / gcd) * b in 64 bits, zero when either operand is zero.
    function automatic t_gcd_lcm_req calc_gcd_lcm(input t_word a, input t_word b);
        t_gcd_lcm_req res;
        t_word x;
        t_word y;
        t_word r;
        x = a;
        y = b;
        while (y != '0) begin
            r = x % y;
            x = y;
            y = r;
        end
        res.a        = a;
        res.b        = b;
        res.divisor  = x;
        res.multiple = '0;
        res.undef    = 1'b0;
        if (a == '0 && b == '0) begin
            res.undef = 1'b1;
        end else if (a != '0 && b != '0) begin
            res.multiple = t_prod'(a / x) * t_prod'(b);
        end
        return res;
    endfunction

    // Draw an operand pair. Two pairs in five are plain random; the rest aim at the
    // corners: shared factors, small values, many trailing zeros, zeros, equal.
    task automatic make_random_pair(output t_word a, output t_word b);
        int unsigned pick;
        t_word g;
        pick = $urandom_range(99);
        if (pick < 40) begin
            a = $urandom();
            b = $urandom();
        end else if (pick < 60) begin
            g = $urandom_range(1, 32'hFFFF) << $urandom_range(0, 8);
            a = g * $urandom_range(1, 32'hFFFF_FFFF / g);
            b = g * $urandom_range(1, 32'hFFFF_FFFF / g);
        end else if (pick < 72) begin
            a = $urandom_range(0, 1000);
            b = $urandom_range(0, 1000);
        end else if (pick < 82) begin
            a = ($urandom() | 32'h1) << $urandom_range(0, 31);
            b = ($urandom() | 32'h1) << $urandom_range(0, 31);
        end else if (pick < 90) begin
            if ($urandom_range(1) == 0) begin
                a = '0;
                b = $urandom();
            end else begin
                a = $urandom();
                b = '0;
            end
        end else if (pick < 93) begin
            a = '0;
            b = '0;
        end else begin
            a = $urandom();
            b = a;
        end
    endtask

    // Offer one request, idling first at random, and hold it until accepted.
    // Valid is set once per edge: either low for an idle cycle or high with data.
    task automatic send_request(input t_gcd_lcm_req req);
        while (in_idle_on && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_first_value  <= req.a;
        i_second_value <= req.b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_res.push_back(req);
        n_sent++;
        if (req.a == '0 || req.b == '0) n_zero_ops++;
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string field, input t_gcd_lcm_req want,
                                   input t_prod got);
        errors++;
        $display("%0t: %s mismatch for a=%h b=%h: expected %h, got %h",
                 $time, field, want.a, want.b, want.multiple, got);
    endtask

    // Stimulus: reset, directed rows, then random requests in phases.
    initial begin : stimulus
        t_gcd_lcm_req req;
        int i;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; typed answers are used as they stand.
        for (i = 0; i < N_DIRECTED; i++) begin
            if (dir_rows[i].typed) begin
                req.a        = dir_rows[i].a;
                req.b        = dir_rows[i].b;
                req.divisor  = dir_rows[i].divisor;
                req.multiple = dir_rows[i].multiple;
                req.undef    = dir_rows[i].undef;
            end else begin
                req = calc_gcd_lcm(dir_rows[i].a, dir_rows[i].b);
            end
            send_request(req);
        end
        drain_results();

        for (i = 0; i < N_RANDOM; i++) begin
            // Run a stretch with both sides at full rate, then idle again.
            if (i == 400) begin
                in_idle_on  = 1'b0;
                out_idle_on = 1'b0;
            end
            if (i == 800) begin
                in_idle_on  = 1'b1;
                out_idle_on = 1'b1;
            end
            // Hold the output long enough that the input backs up.
            if (i == 900) hold_off_req = 1'b1;
            // Pause the sender until the block has emptied out.
            if (i == 1200) drain_results();
            make_random_pair(req.a, req.b);
            req = calc_gcd_lcm(req.a, req.b);
            send_request(req);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests (%0d with a zero operand) and checked %0d results,",
                 n_sent, n_zero_ops, n_checked);
        $display("with random idling on both sides, %0d long output hold-off(s) and drains.",
                 n_holds);
        if (errors == 0 && pending_res.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Output side: random stall, or a long hold-off counted here in cycles.
    initial begin : result_side
        int k;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                n_holds++;
                i_out_stall <= 1'b1;
                for (k = 1; k < HOLD_CYCLES; k++) @(posedge i_clk);
            end else begin
                i_out_stall <= out_idle_on && ($urandom_range(99) < 33);
            end
        end
    end

    // Compare every taken result with the oldest owed one, field by field.
    always @(posedge i_clk) begin : result_check
        t_gcd_lcm_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_res.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: divisor %h, multiple %h, flag %b",
                         $time, o_divisor_result, o_multiple_result, o_undefined_flag);
            end else begin
                want = pending_res.pop_front();
                n_checked++;
                if (o_divisor_result !== want.divisor) begin
                    errors++;
                    $display("%0t: divisor mismatch for a=%h b=%h: expected %h, got %h",
                             $time, want.a, want.b, want.divisor, o_divisor_result);
                end
                if (o_multiple_result !== want.multiple)
                    report_mismatch("multiple", want, o_multiple_result);
                if (o_undefined_flag !== want.undef) begin
                    errors++;
                    $display("%0t: flag mismatch for a=%h b=%h: expected %b, got %b",
                             $time, want.a, want.b, want.undef, o_undefined_flag);
                end
            end
        end
    end

    // Watchdog: end the run if it goes far past the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_res.size());
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

FILE: filelist.f
src/glu_pkg.sv
src/glu_divider.sv
src/gcd_lcm_unit_top.sv
tb/tb_gcd_lcm_unit_top.sv
